// File: rtl/hex_spiral_coordinate_generator_macros.svh
// Assertion macros shared by the hex spiral generator modules.
`ifndef HEX_SPIRAL_COORDINATE_GENERATOR_MACROS_SVH
`define HEX_SPIRAL_COORDINATE_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checked while out of reset.
`define HSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HSC_ASSERT(label, clk, rst, prop, msg)
`define HSC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

  // Largest ring that can be emitted, and coordinate arithmetic width.
  localparam int MAX_RADIUS  = 4;
  localparam int COORD_WIDTH = 16;

  // Port field widths.
  localparam int RADIUS_W = 4;
  localparam int FIELD_W  = 16;
  localparam int DIR_W    = 3;

  // Ring and step counter width, enough for 0..MAX_RADIUS + 1.
  localparam int RING_W = $clog2(MAX_RADIUS + 1);

  // Neighbor directions.
  localparam int DIR_COUNT = 6;
  localparam logic [DIR_W-1:0] DIR_EAST      = DIR_W'(0);
  localparam logic [DIR_W-1:0] DIR_NORTHEAST = DIR_W'(1);
  localparam logic [DIR_W-1:0] DIR_NORTHWEST = DIR_W'(2);
  localparam logic [DIR_W-1:0] DIR_WEST      = DIR_W'(3);
  localparam logic [DIR_W-1:0] DIR_SOUTHWEST = DIR_W'(4);
  localparam logic [DIR_W-1:0] DIR_SOUTHEAST = DIR_W'(5);
  localparam logic [DIR_W-1:0] DIR_RESET     = DIR_SOUTHWEST;
  localparam logic [DIR_W-1:0] LAST_SIDE     = DIR_SOUTHEAST;

  typedef logic [DIR_W-1:0]               dir_t;
  typedef logic [RING_W-1:0]              ring_t;
  typedef logic signed [COORD_WIDTH-1:0]  coord_t;

  typedef struct packed {
    logic signed [RADIUS_W-1:0] outer_radius;
    logic signed [RADIUS_W-1:0] inner_radius;
    logic signed [FIELD_W-1:0]  center_q;
    logic signed [FIELD_W-1:0]  center_r;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cell_q;
    logic signed [FIELD_W-1:0] cell_r;
    logic                      present;
    logic                      last;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } hsc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_cell;
  } hsc_status_t;

  // Register value 6 and 7 act as 0 and 1.
  function automatic dir_t dir_fold(input dir_t d);
    dir_t res;
    if (d >= DIR_W'(DIR_COUNT)) begin
      res = d - DIR_W'(DIR_COUNT);
    end else begin
      res = d;
    end
    return res;
  endfunction

  // Sign of the q offset of a direction.
  function automatic logic signed [1:0] dir_dq(input dir_t d);
    logic signed [1:0] res;
    case (d)
      DIR_EAST, DIR_NORTHEAST: res = 2'sd1;
      DIR_WEST, DIR_SOUTHWEST: res = -2'sd1;
      default:                 res = 2'sd0;
    endcase
    return res;
  endfunction

  // Sign of the r offset of a direction.
  function automatic logic signed [1:0] dir_dr(input dir_t d);
    logic signed [1:0] res;
    case (d)
      DIR_SOUTHWEST, DIR_SOUTHEAST: res = 2'sd1;
      DIR_NORTHEAST, DIR_NORTHWEST: res = -2'sd1;
      default:                      res = 2'sd0;
    endcase
    return res;
  endfunction

  // Unit offset times a ring radius: just +k, 0 or -k.
  function automatic coord_t scale_offset(input logic signed [1:0] unit, input ring_t k);
    coord_t kk;
    coord_t res;
    kk = coord_t'({1'b0, k});
    if (unit > 2'sd0) begin
      res = kk;
    end else if (unit < 2'sd0) begin
      res = -kk;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

// File: rtl/hsc_ctrl.sv
`timescale 1ns / 1ps
`include "hex_spiral_coordinate_generator_macros.svh"

module hsc_ctrl
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output hsc_cmd_t    cmd,
  input  hsc_status_t status
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  logic   slot_busy;

  // Output register still holds a beat that will not leave this cycle.
  assign slot_busy = out_valid && out_stall;

  // Take a request only when idle and the output register can absorb a marker.
  assign in_stall = (state != S_IDLE) || slot_busy;
  assign cmd.load = in_valid && !in_stall;
  assign cmd.emit = (state == S_RUN) && !slot_busy;

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cmd.emit && status.last_cell) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HSC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE) && !out_valid, "reset did not clear controller")
  `HSC_ASSERT(a_last_to_idle, clk, rst, cmd.emit && status.last_cell |=> state == S_IDLE, "no return to idle after last beat")
  `HSC_ASSERT(a_load_runs, clk, rst, cmd.load |=> (state == S_RUN) && !cmd.load, "request accepted while walking")
  `HSC_ASSERT(a_held_beat, clk, rst, out_valid && out_stall |=> out_valid, "stalled beat dropped")

endmodule

// File: rtl/hsc_datapath.sv
`timescale 1ns / 1ps
`include "hex_spiral_coordinate_generator_macros.svh"

module hsc_datapath
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  dir_t        cfg_data,
  input  req_t        req,
  input  hsc_cmd_t    cmd,
  output hsc_status_t status,
  output res_t        res
);

  localparam logic signed [RADIUS_W-1:0] RAD_MAX  = RADIUS_W'(MAX_RADIUS);
  localparam logic signed [RADIUS_W-1:0] RAD_NONE = -RADIUS_W'(1);

  dir_t   start_direction;
  coord_t hub_q, hub_r, walk_q, walk_r;
  ring_t  ring, step, outer_held;
  dir_t   side;
  logic   marker;

  dir_t   sd;
  logic signed [RADIUS_W-1:0] outer_c, inner_c, first_ring;
  logic   empty_req;
  ring_t  ring_first;
  coord_t in_q, in_r;

  ring_t  ring_inc;
  logic   side_end, ring_end;

  assign sd = dir_fold(start_direction);

  // Request decode: clamp radii, pick first ring.
  always_comb begin
    outer_c    = (req.outer_radius > RAD_MAX) ? RAD_MAX : req.outer_radius;
    inner_c    = (req.inner_radius < RAD_NONE) ? RAD_NONE : req.inner_radius;
    empty_req  = inner_c >= outer_c;
    first_ring = inner_c + RADIUS_W'(1);
    ring_first = first_ring[RING_W-1:0];
    in_q       = coord_t'(req.center_q);
    in_r       = coord_t'(req.center_r);
  end

  // Walk position bookkeeping.
  assign ring_inc  = ring + RING_W'(1);
  assign side_end  = (step == ring - RING_W'(1));
  assign ring_end  = (ring == '0) || ((side == LAST_SIDE) && side_end);
  assign status.last_cell = marker || ((ring == outer_held) && ring_end);

  // Start direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_direction <= DIR_RESET;
    end else if (cfg_write) begin
      start_direction <= cfg_data;
    end
  end

  // Walk registers: load on accept, advance one cell per emitted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring       <= '0;
      side       <= '0;
      step       <= '0;
      outer_held <= '0;
      marker     <= 1'b0;
      hub_q      <= '0;
      hub_r      <= '0;
      walk_q     <= '0;
      walk_r     <= '0;
    end else if (cmd.load) begin
      marker     <= empty_req;
      outer_held <= outer_c[RING_W-1:0];
      ring       <= ring_first;
      side       <= '0;
      step       <= '0;
      hub_q      <= in_q;
      hub_r      <= in_r;
      walk_q     <= in_q + scale_offset(dir_dq(sd), ring_first);
      walk_r     <= in_r + scale_offset(dir_dr(sd), ring_first);
    end else if (cmd.emit) begin
      if (ring_end) begin
        ring   <= ring_inc;
        side   <= '0;
        step   <= '0;
        walk_q <= hub_q + scale_offset(dir_dq(sd), ring_inc);
        walk_r <= hub_r + scale_offset(dir_dr(sd), ring_inc);
      end else begin
        if (side_end) begin
          side <= side + DIR_W'(1);
          step <= '0;
        end else begin
          step <= step + RING_W'(1);
        end
        walk_q <= walk_q + coord_t'(dir_dq(side));
        walk_r <= walk_r + coord_t'(dir_dr(side));
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (marker) begin
        res.cell_q  <= '0;
        res.cell_r  <= '0;
        res.present <= 1'b0;
        res.last    <= 1'b1;
      end else begin
        res.cell_q  <= FIELD_W'(walk_q);
        res.cell_r  <= FIELD_W'(walk_r);
        res.present <= 1'b1;
        res.last    <= status.last_cell;
      end
    end
  end

  // The ring counter steps one past the outer ring after the final beat.
  `HSC_ASSERT(a_ring_range, clk, rst, ring <= RING_W'(MAX_RADIUS + 1) || marker, "ring beyond max radius")
  `HSC_ASSERT(a_step_range, clk, rst, (step == '0) || (step < ring), "step beyond side length")
  `HSC_ASSERT(a_side_range, clk, rst, side < DIR_W'(DIR_COUNT), "side beyond last direction")

endmodule

// File: rtl/hex_spiral_coordinate_generator.sv
`timescale 1ns / 1ps

// Hex spiral coordinate generator. Each request beat (outer radius, inner
// radius, axial center) yields the cells of rings inner+1..outer, ring by
// ring, each ring starting at center + radius * offset of start_direction
// and walking six sides in directions 0..5; a negative inner radius puts
// the center cell first, and an empty range gives one marker beat with
// present=0, last=1. Outer radius saturates at MAX_RADIUS, coordinates
// wrap at COORD_WIDTH bits. After a request is accepted, result beats are
// produced from the walk counters (ring, side, step), held while out_stall
// keeps a beat in the output register; the next request is taken once the
// last beat has been handed to the output register and is not held there by
// out_stall. start_direction (reset 4) is written through cfg_write/cfg_data;
// the user must write it only while the block is idle; it is not enforced.
module hex_spiral_coordinate_generator
  import hsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data,
  input  logic cfg_write,
  input  dir_t cfg_data
);

  hsc_cmd_t    cmd;
  hsc_status_t status;

  hsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  hsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (in_data),
    .cmd       (cmd),
    .status    (status),
    .res       (out_data)
  );

endmodule
